// ===== rtl/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types and constants for the space vector PWM generator: field
// widths, parameter defaults, the sector labels and the record passed from
// the front-end pipeline to the timing back end.
// ----------------------------------------------------------------------------
package svpwm_pkg;

    localparam int IN_W     = 16;  // v_alpha / v_beta
    localparam int DUTY_W   = 16;  // compare value outputs
    localparam int CFG_W    = 16;  // pwm_period write data
    localparam int SECTOR_W = 3;
    localparam int RED_W    = 17;  // active time after rounding to 2^-F units

    localparam int PERIOD_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF    = 15;

    localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd1000;

    // sqrt(3)/2 in Q0.32
    localparam logic [63:0] SQRT3_BY2_Q32 = 64'd3719550787;

    typedef enum logic [SECTOR_W-1:0] {
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5,
        SECTOR_6 = 3'd6
    } sector_t;

    // Output of the front end: sector and the two adjacent active times
    typedef struct packed {
        logic             valid;
        sector_t          sector;
        logic [RED_W-1:0] t1;
        logic [RED_W-1:0] t2;
    } front_t;

endpackage

// ===== rtl/svpwm_front.sv =====
// ----------------------------------------------------------------------------
// svpwm_front
// Three-stage front end: scales alpha by sqrt(3)/2, forms the three
// reference voltages, decodes the sector and rounds the two active times.
// ----------------------------------------------------------------------------
module svpwm_front #(
    parameter int FRAC_BITS = svpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [svpwm_pkg::IN_W-1:0]    v_alpha,
    input  logic signed [svpwm_pkg::IN_W-1:0]    v_beta,
    output svpwm_pkg::front_t                    front_out,
    input  logic                                 front_ready
);
    import svpwm_pkg::*;

    localparam int KAW  = FRAC_BITS + IN_W + 1;
    localparam int VW   = FRAC_BITS + IN_W + 2;
    localparam int VW1  = VW + 1;
    localparam logic [63:0] K64 =
        (SQRT3_BY2_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [FRAC_BITS:0] K_COEF = {1'b0, K64[FRAC_BITS-1:0]};
    localparam logic [VW:0] HALF_RND = VW1'(64'd1 << (FRAC_BITS - 1));

    // stage enables: a stage loads when empty or when its contents move on
    logic en_f1, en_f2, en_f3;

    // stage 1: alpha product
    logic                  f1_valid_reg;
    logic signed [KAW-1:0] ka_reg, ka_next;
    logic signed [IN_W-1:0] b1_reg;

    // stage 2: references
    logic                 f2_valid_reg;
    logic signed [VW-1:0] vr2_reg, vr2_next;
    logic signed [VW-1:0] vr2n_reg, vr2n_next;
    logic signed [VW-1:0] vr3_reg, vr3_next;
    logic signed [VW-1:0] vr3n_reg, vr3n_next;
    logic [VW-1:0]        vr1_abs_reg, vr1_abs_next;
    logic                 b_neg_reg;
    logic signed [VW-1:0] b_ext, ka_ext, hb;

    // stage 3: sector and rounded times
    logic             f3_valid_reg;
    sector_t          f3_sector_reg, sector_next;
    logic [RED_W-1:0] f3_t1_reg, f3_t2_reg, t1_next, t2_next;
    logic [VW-1:0]    t1_sel, t2_sel;
    logic [VW:0]      t1_rnd, t2_rnd;

    assign en_f3    = !f3_valid_reg || front_ready;
    assign en_f2    = !f2_valid_reg || en_f3;
    assign en_f1    = !f1_valid_reg || en_f2;
    assign in_ready = en_f1;

    assign ka_next = KAW'(v_alpha) * KAW'($signed(K_COEF));

    assign b_ext  = {{(VW - IN_W){b1_reg[IN_W-1]}}, b1_reg};
    assign ka_ext = {{(VW - KAW){ka_reg[KAW-1]}}, ka_reg};
    assign hb     = b_ext <<< (FRAC_BITS - 1);

    assign vr2_next  = ka_ext - hb;
    assign vr2n_next = hb - ka_ext;
    assign vr3_next  = -hb - ka_ext;
    assign vr3n_next = hb + ka_ext;
    assign vr1_abs_next = b1_reg[IN_W-1] ? VW'((-b_ext) <<< FRAC_BITS)
                                         : VW'(b_ext <<< FRAC_BITS);

    // sector decode on the exact reference signs
    always_comb
    begin
        if (!b_neg_reg)
        begin
            if (!vr2_reg[VW-1])
            begin
                sector_next = SECTOR_3;
                t1_sel      = vr2_reg;
                t2_sel      = vr1_abs_reg;
            end
            else if (!vr3_reg[VW-1])
            begin
                sector_next = SECTOR_5;
                t1_sel      = vr1_abs_reg;
                t2_sel      = vr3_reg;
            end
            else
            begin
                sector_next = SECTOR_1;
                t1_sel      = vr2n_reg;
                t2_sel      = vr3n_reg;
            end
        end
        else
        begin
            if (!vr2_reg[VW-1])
            begin
                if (!vr3_reg[VW-1])
                begin
                    sector_next = SECTOR_6;
                    t1_sel      = vr3_reg;
                    t2_sel      = vr2_reg;
                end
                else
                begin
                    sector_next = SECTOR_2;
                    t1_sel      = vr3n_reg;
                    t2_sel      = vr1_abs_reg;
                end
            end
            else
            begin
                sector_next = SECTOR_4;
                t1_sel      = vr1_abs_reg;
                t2_sel      = vr2n_reg;
            end
        end
    end

    // round half up to 2^-F units
    assign t1_rnd  = {1'b0, t1_sel} + HALF_RND;
    assign t2_rnd  = {1'b0, t2_sel} + HALF_RND;
    assign t1_next = t1_rnd[FRAC_BITS+RED_W-1:FRAC_BITS];
    assign t2_next = t2_rnd[FRAC_BITS+RED_W-1:FRAC_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_f1)
                f1_valid_reg <= in_valid;
            if (en_f2)
                f2_valid_reg <= f1_valid_reg;
            if (en_f3)
                f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f1)
        begin
            ka_reg <= ka_next;
            b1_reg <= v_beta;
        end
        if (en_f2)
        begin
            vr2_reg     <= vr2_next;
            vr2n_reg    <= vr2n_next;
            vr3_reg     <= vr3_next;
            vr3n_reg    <= vr3n_next;
            vr1_abs_reg <= vr1_abs_next;
            b_neg_reg   <= b1_reg[IN_W-1];
        end
        if (en_f3)
        begin
            f3_sector_reg <= sector_next;
            f3_t1_reg     <= t1_next;
            f3_t2_reg     <= t2_next;
        end
    end

    assign front_out.valid  = f3_valid_reg;
    assign front_out.sector = f3_sector_reg;
    assign front_out.t1     = f3_t1_reg;
    assign front_out.t2     = f3_t2_reg;

endmodule

// ===== rtl/space_vector_pwm_generator.sv =====
// ----------------------------------------------------------------------------
// space_vector_pwm_generator
// Space vector PWM: turns one alpha/beta voltage vector into three centered
// compare values and a sector label.
// ----------------------------------------------------------------------------
// Usage: drive v_alpha / v_beta (signed Q1.15, 1.0 = one full period) with
// in_valid; each transfer yields exactly one result (duty_phase_a/b/c and
// sector_code). The block is a seven-stage pipeline and accepts one vector
// every clock cycle while in_stall is low: three front stages (alpha times
// sqrt(3)/2, reference voltages, sector decode and rounding of the active
// times) and four back stages (active times times the period, centered
// zero-vector time, the edge times ta and tb, phase permutation with saturation
// into the output register). Stalls fill bubbles first, so inputs keep
// flowing while a result waits at the output.
// Compare values are saturated to 0..pwm_period when the vector lies outside
// the hexagon. pwm_period is written through the cfg channel, which is always
// ready; write it only while no vector is in flight.
// ----------------------------------------------------------------------------
module space_vector_pwm_generator #(
    parameter int PERIOD_WIDTH = svpwm_pkg::PERIOD_WIDTH_DEF,
    parameter int FRAC_BITS    = svpwm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // vector input
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [svpwm_pkg::IN_W-1:0]   v_alpha,
    input  logic signed [svpwm_pkg::IN_W-1:0]   v_beta,
    // compare value output
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_phase_a,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_phase_b,
    output logic [svpwm_pkg::DUTY_W-1:0]        duty_phase_c,
    output logic [svpwm_pkg::SECTOR_W-1:0]      sector_code,
    // period write
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [svpwm_pkg::CFG_W-1:0]         pwm_period
);
    import svpwm_pkg::*;

    // stored period keeps the low min(PERIOD_WIDTH, CFG_W) bits of a write,
    // but must still hold the reset value
    localparam int PER_W  = (PERIOD_WIDTH < CFG_W) ? PERIOD_WIDTH : CFG_W;
    localparam int PREG_W = (PER_W > 10) ? PER_W : 10;
    localparam int PW     = RED_W + PREG_W;
    localparam int SW     = ((PREG_W + FRAC_BITS > PW + 1) ? PREG_W + FRAC_BITS
                                                           : PW + 1) + 2;
    localparam logic [CFG_W-1:0] PERIOD_MASK =
        CFG_W'((64'd1 << PER_W) - 64'd1);
    localparam logic signed [SW-1:0] HALF_S = SW'(64'd1 << (FRAC_BITS - 1));

    // ------------------------------------------------------------------
    // Period register
    // ------------------------------------------------------------------
    logic [PREG_W-1:0] period_reg, period_next;

    assign cfg_ready   = 1'b1;
    assign period_next = PREG_W'(pwm_period & PERIOD_MASK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= PREG_W'(PERIOD_RESET);
        else if (cfg_valid && cfg_ready)
            period_reg <= period_next;
    end

    // full scale in 2^-F count units
    logic signed [SW-1:0] full_s;
    assign full_s = $signed(SW'({period_reg, {FRAC_BITS{1'b0}}}));

    // ------------------------------------------------------------------
    // Front end: sector decode and rounded active times
    // ------------------------------------------------------------------
    front_t front;
    logic   front_ready;
    logic   in_ready;

    svpwm_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .v_alpha     (v_alpha),
        .v_beta      (v_beta),
        .front_out   (front),
        .front_ready (front_ready)
    );

    assign in_stall = !in_ready;

    // ------------------------------------------------------------------
    // Back end pipeline control: each stage advances when empty or when
    // the stage after it advances
    // ------------------------------------------------------------------
    logic en_b1, en_b2, en_b3, en_out;
    logic b1_valid_reg, b2_valid_reg, b3_valid_reg, out_valid_reg;

    assign en_out      = !out_valid_reg || !out_stall;
    assign en_b3       = !b3_valid_reg || en_out;
    assign en_b2       = !b2_valid_reg || en_b3;
    assign en_b1       = !b1_valid_reg || en_b2;
    assign front_ready = en_b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en_b1)
                b1_valid_reg <= front.valid;
            if (en_b2)
                b2_valid_reg <= b1_valid_reg;
            if (en_b3)
                b3_valid_reg <= b2_valid_reg;
            if (en_out)
                out_valid_reg <= b3_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B1: scale both active times by the period
    // ------------------------------------------------------------------
    sector_t       b1_sector_reg;
    logic [PW-1:0] b1_p1_reg, b1_p2_reg, p1_next, p2_next;

    assign p1_next = PW'(front.t1) * PW'(period_reg);
    assign p2_next = PW'(front.t2) * PW'(period_reg);

    // ------------------------------------------------------------------
    // Stage B2: zero-vector time tc = floor((full - t1 - t2) / 2)
    // ------------------------------------------------------------------
    sector_t              b2_sector_reg;
    logic signed [SW-1:0] b2_tc_reg, tc_next, tc_diff;
    logic [PW-1:0]        b2_p2_reg;
    logic [PW:0]          b2_sum_reg, sum_next;

    assign sum_next = {1'b0, b1_p1_reg} + {1'b0, b1_p2_reg};
    assign tc_diff  = full_s - $signed(SW'(sum_next));
    assign tc_next  = tc_diff >>> 1;

    // ------------------------------------------------------------------
    // Stage B3: tb = tc + t2, ta = tc + t1 + t2
    // ------------------------------------------------------------------
    sector_t              b3_sector_reg;
    logic signed [SW-1:0] b3_ta_reg, b3_tb_reg, b3_tc_reg, ta_next, tb_next;

    assign tb_next = b2_tc_reg + $signed(SW'(b2_p2_reg));
    assign ta_next = b2_tc_reg + $signed(SW'(b2_sum_reg));

    // ------------------------------------------------------------------
    // Stage B4: hand the times to the phases, saturate, round to counts
    // ------------------------------------------------------------------
    logic signed [SW-1:0] pa, pb, pc;
    logic [DUTY_W-1:0]    duty_a_reg, duty_b_reg, duty_c_reg;
    logic [DUTY_W-1:0]    duty_a_next, duty_b_next, duty_c_next;
    sector_t              sector_reg;

    function automatic logic [PREG_W-1:0] to_counts(
        input logic signed [SW-1:0] x,
        input logic signed [SW-1:0] full,
        input logic [PREG_W-1:0]    per
    );
        logic signed [SW-1:0] rnd;
        rnd = x + HALF_S;
        if (x <= 0)
            to_counts = '0;
        else if (x >= full)
            to_counts = per;
        else
            to_counts = rnd[FRAC_BITS+PREG_W-1:FRAC_BITS];
    endfunction

    always_comb
    begin
        case (b3_sector_reg)
            SECTOR_3:
            begin
                pa = b3_ta_reg; pb = b3_tb_reg; pc = b3_tc_reg;
            end
            SECTOR_5:
            begin
                pa = b3_tc_reg; pb = b3_ta_reg; pc = b3_tb_reg;
            end
            SECTOR_1:
            begin
                pa = b3_tb_reg; pb = b3_ta_reg; pc = b3_tc_reg;
            end
            SECTOR_6:
            begin
                pa = b3_tb_reg; pb = b3_tc_reg; pc = b3_ta_reg;
            end
            SECTOR_2:
            begin
                pa = b3_ta_reg; pb = b3_tc_reg; pc = b3_tb_reg;
            end
            default:
            begin
                pa = b3_tc_reg; pb = b3_tb_reg; pc = b3_ta_reg;
            end
        endcase
    end

    assign duty_a_next = DUTY_W'(to_counts(pa, full_s, period_reg));
    assign duty_b_next = DUTY_W'(to_counts(pb, full_s, period_reg));
    assign duty_c_next = DUTY_W'(to_counts(pc, full_s, period_reg));

    // payload registers; they load only when their stage advances
    always_ff @(posedge clk)
    begin
        if (en_b1)
        begin
            b1_sector_reg <= front.sector;
            b1_p1_reg     <= p1_next;
            b1_p2_reg     <= p2_next;
        end
        if (en_b2)
        begin
            b2_sector_reg <= b1_sector_reg;
            b2_tc_reg     <= tc_next;
            b2_p2_reg     <= b1_p2_reg;
            b2_sum_reg    <= sum_next;
        end
        if (en_b3)
        begin
            b3_sector_reg <= b2_sector_reg;
            b3_ta_reg     <= ta_next;
            b3_tb_reg     <= tb_next;
            b3_tc_reg     <= b2_tc_reg;
        end
        if (en_out)
        begin
            sector_reg <= b3_sector_reg;
            duty_a_reg <= duty_a_next;
            duty_b_reg <= duty_b_next;
            duty_c_reg <= duty_c_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign duty_phase_a = duty_a_reg;
    assign duty_phase_b = duty_b_reg;
    assign duty_phase_c = duty_c_reg;
    assign sector_code  = sector_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // an empty output stage lets every stage advance, so the input is free
    a_no_stall_when_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall
    ) else $error("input stalled while the output stage is empty");

    // in sector 3 phase A carries ta, B tb and C tc
    a_sector3_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sector_reg == SECTOR_3) |->
            (duty_a_reg >= duty_b_reg && duty_b_reg >= duty_c_reg)
    ) else $error("phase order broken in sector 3");

    // in sector 4 phase C carries ta, B tb and A tc
    a_sector4_order: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sector_reg == SECTOR_4) |->
            (duty_c_reg >= duty_b_reg && duty_b_reg >= duty_a_reg)
    ) else $error("phase order broken in sector 4");

endmodule
